/* hdl/aled_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aled_pkg;

	localparam int unsigned MAX_CHAIN = 1024;
	localparam int unsigned BITS_PER_PIXEL = 24;
	localparam int unsigned COLOR_BITS = 24;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned CHAIN_W = 11;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LATCH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAIN_LENGTH = 3'd4;

	localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 16'd40;
	localparam logic [TICK_W-1:0] ONE_HIGH_RESET = 16'd87;
	localparam logic [TICK_W-1:0] BIT_PERIOD_RESET = 16'd156;
	localparam logic [TICK_W-1:0] LATCH_RESET = 16'd12500;
	localparam logic [CHAIN_W-1:0] CHAIN_LENGTH_RESET = 11'd64;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CHAIN = 2'd1;
	localparam logic [1:0] ERR_FULL = 2'd2;
	localparam logic [1:0] ERR_UNDERRUN = 2'd3;

	typedef struct packed {
		logic       operation;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
		logic       last_pixel;
	} in_t;

	typedef struct packed {
		logic       line_level;
		logic       accepted;
		logic [1:0] phase;
		logic [1:0] error_code;
		logic       frame_done;
	} out_t;

endpackage

`default_nettype wire

/* hdl/addressable_led_bit_encoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// One-wire LED strip encoder. Every input transfer is one tick of the bit timing and may
// offer a pixel; each yields exactly one registered result transfer. The engine state is
// updated in a single registered pass per tick, so a new tick is taken in every cycle
// while in_stall is low. Results go through a two-entry output buffer, and in_stall
// rises only when both entries are full, so a waiting result does not block the next
// tick. The user must write timing registers via cfg port only while idle (unenforced).

module addressable_led_bit_encoder_top #(
	parameter int unsigned BITS_PER_PIXEL = aled_pkg::BITS_PER_PIXEL
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  aled_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output aled_pkg::out_t                      out_data,
	input  wire                                 cfg_we,
	input  wire [aled_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [aled_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned BIT_W = $clog2(BITS_PER_PIXEL);
	localparam int unsigned TW = aled_pkg::TICK_W;
	localparam int unsigned CW = aled_pkg::CHAIN_W;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SEND  = 2'd1,
		MODE_LATCH = 2'd2
	} mode_t;

	logic [TW-1:0] zero_high_q;
	logic [TW-1:0] one_high_q;
	logic [TW-1:0] bit_period_q;
	logic [TW-1:0] latch_q;
	logic [CW-1:0] chain_length_q;

	mode_t                          mode_q, mode_d;
	logic [aled_pkg::COLOR_BITS-1:0] shift_q, shift_d;
	logic [aled_pkg::COLOR_BITS-1:0] hold_pixel_q, hold_pixel_d;
	logic                           hold_valid_q, hold_valid_d;
	logic                           hold_last_q, hold_last_d;
	logic                           cur_last_q, cur_last_d;
	logic [BIT_W-1:0]               bit_index_q, bit_index_d;
	logic [TW-1:0]                  tick_q, tick_d;
	logic [CW-1:0]                  pixels_q, pixels_d;

	aled_pkg::out_t res;
	aled_pkg::out_t out_q;
	aled_pkg::out_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;

	logic           in_acc;
	logic           out_take;
	logic [TW:0]    tick_inc;
	logic           cur_bit;
	logic [TW-1:0]  high_ticks;
	logic [CW-1:0]  limit;

	assign in_stall = skid_valid_q;
	assign in_acc = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_take = out_valid_q && !out_stall;
	assign tick_inc = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= aled_pkg::ZERO_HIGH_RESET;
			one_high_q <= aled_pkg::ONE_HIGH_RESET;
			bit_period_q <= aled_pkg::BIT_PERIOD_RESET;
			latch_q <= aled_pkg::LATCH_RESET;
			chain_length_q <= aled_pkg::CHAIN_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				aled_pkg::REG_ZERO_HIGH: zero_high_q <= cfg_data;
				aled_pkg::REG_ONE_HIGH: one_high_q <= cfg_data;
				aled_pkg::REG_BIT_PERIOD: bit_period_q <= cfg_data;
				aled_pkg::REG_LATCH: latch_q <= cfg_data;
				aled_pkg::REG_CHAIN_LENGTH: chain_length_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d = mode_q;
		shift_d = shift_q;
		hold_pixel_d = hold_pixel_q;
		hold_valid_d = hold_valid_q;
		hold_last_d = hold_last_q;
		cur_last_d = cur_last_q;
		bit_index_d = bit_index_q;
		tick_d = tick_q;
		pixels_d = pixels_q;
		res = '0;
		res.phase = mode_q;
		res.error_code = aled_pkg::ERR_NONE;
		cur_bit = 1'b0;
		high_ticks = zero_high_q;
		limit = chain_length_q;

		case (mode_q)
			MODE_IDLE: begin
				if (hold_valid_q) begin
					shift_d = hold_pixel_q;
					cur_last_d = hold_last_q;
					hold_valid_d = 1'b0;
					bit_index_d = '0;
					tick_d = '0;
					mode_d = MODE_SEND;
				end
			end
			MODE_SEND: begin
				if (int'(bit_index_q) < int'(aled_pkg::COLOR_BITS)) begin
					cur_bit = shift_q[5'(int'(aled_pkg::COLOR_BITS) - 1 - int'(bit_index_q))];
				end
				high_ticks = cur_bit ? one_high_q : zero_high_q;
				res.line_level = (tick_q < high_ticks);
				tick_d = tick_inc[TW-1:0];
				if (tick_inc >= {1'b0, bit_period_q}) begin
					tick_d = '0;
					if (int'(bit_index_q) + 1 >= int'(BITS_PER_PIXEL)) begin
						bit_index_d = '0;
						if (cur_last_q) begin
							mode_d = MODE_LATCH;
						end else if (hold_valid_q) begin
							shift_d = hold_pixel_q;
							cur_last_d = hold_last_q;
							hold_valid_d = 1'b0;
						end else begin
							res.error_code = aled_pkg::ERR_UNDERRUN;
							mode_d = MODE_LATCH;
							pixels_d = '0;
						end
					end else begin
						bit_index_d = BIT_W'(bit_index_q + 1'b1);
					end
				end
			end
			MODE_LATCH: begin
				tick_d = tick_inc[TW-1:0];
				if (tick_inc >= {1'b0, latch_q}) begin
					tick_d = '0;
					res.frame_done = 1'b1;
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		if (in_data.operation) begin
			if (int'(chain_length_q) > int'(aled_pkg::MAX_CHAIN)) begin
				limit = CW'(aled_pkg::MAX_CHAIN);
			end
			if (pixels_d >= limit) begin
				res.error_code = aled_pkg::ERR_CHAIN;
			end else if (hold_valid_d) begin
				res.error_code = aled_pkg::ERR_FULL;
			end else begin
				hold_pixel_d = {in_data.green, in_data.red, in_data.blue};
				hold_last_d = in_data.last_pixel;
				hold_valid_d = 1'b1;
				res.accepted = 1'b1;
				pixels_d = in_data.last_pixel ? '0 : CW'(pixels_d + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			shift_q <= '0;
			hold_pixel_q <= '0;
			hold_valid_q <= 1'b0;
			hold_last_q <= 1'b0;
			cur_last_q <= 1'b0;
			bit_index_q <= '0;
			tick_q <= '0;
			pixels_q <= '0;
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				mode_q <= mode_d;
				shift_q <= shift_d;
				hold_pixel_q <= hold_pixel_d;
				hold_valid_q <= hold_valid_d;
				hold_last_q <= hold_last_d;
				cur_last_q <= cur_last_d;
				bit_index_q <= bit_index_d;
				tick_q <= tick_d;
				pixels_q <= pixels_d;
			end
			if (out_take) begin
				if (skid_valid_q) begin
					out_q <= skid_q;
					skid_valid_q <= 1'b0;
				end else if (in_acc) begin
					out_q <= res;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (in_acc) begin
				if (!out_valid_q) begin
					out_q <= res;
					out_valid_q <= 1'b1;
				end else begin
					skid_q <= res;
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid entry is full while the output register is empty.");

	a_idle_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode_q == MODE_IDLE && hold_valid_q |=> mode_q == MODE_SEND)
		else $error("Idle engine did not load the buffered pixel.");

	a_accept_no_reject: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && res.accepted |->
		res.error_code != aled_pkg::ERR_CHAIN && res.error_code != aled_pkg::ERR_FULL)
		else $error("A pixel was taken and rejected in the same tick.");

	a_done_in_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_done |-> out_q.phase == MODE_LATCH)
		else $error("Frame end was reported outside the latch phase.");

endmodule

`default_nettype wire
